/* hdl/nap_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nap_pkg: shared types and arithmetic for the nested allpass reverb core
// Holds line geometry, register indexes, controller states, command and
// configuration structs, and the fixed-point rounding and saturation helpers.
// ----------------------------------------------------------------------------
package nap_pkg;

	// Delay line depth; a power of two so that the shared index wraps for free
	localparam int LINE_DEPTH = 65536;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);

	localparam int SAMPLE_W = 24;
	localparam int GAIN_W   = 16;
	localparam int DELAY_W  = 16;
	localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
	localparam int RND_W    = SAMPLE_W + 1;
	localparam int SUM_W    = SAMPLE_W + 2;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_OUTER_GAIN  = 2'd0;
	localparam logic [1:0] REG_INNER_GAIN  = 2'd1;
	localparam logic [1:0] REG_OUTER_DELAY = 2'd2;
	localparam logic [1:0] REG_INNER_DELAY = 2'd3;

	localparam logic [GAIN_W-1:0]  RST_OUTER_GAIN  = 16'd42598;
	localparam logic [GAIN_W-1:0]  RST_INNER_GAIN  = 16'd32768;
	localparam logic [DELAY_W-1:0] RST_OUTER_DELAY = 16'd4800;
	localparam logic [DELAY_W-1:0] RST_INNER_DELAY = 16'd8000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_D,
		ST_SUB_V,
		ST_SUB_T,
		ST_MUL_T,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic mul_d;
		logic sub_v;
		logic sub_t;
		logic mul_t;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  outer_gain;
		logic [GAIN_W-1:0]  inner_gain;
		logic [DELAY_W-1:0] outer_delay;
		logic [DELAY_W-1:0] inner_delay;
	} cfg_t;

	// Product / 65536, rounding half up (arithmetic shift of p + 0.5 LSB)
	function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W:0] s;
		s = (PROD_W+1)'(p) + (PROD_W+1)'(32768);
		return s[PROD_W-1:16];
	endfunction

	// Clamp to the 24-bit signed range
	function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SUM_W-1:0] a);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(8388607);
		lo = -SUM_W'(8388608);
		if (a > hi) begin
			return SAMPLE_W'(hi);
		end else if (a < lo) begin
			return SAMPLE_W'(lo);
		end
		return a[SAMPLE_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* hdl/nap_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nap_regs: APB-style configuration registers
// Four 16-bit registers at word addresses; zero-wait writes and reads.
// ----------------------------------------------------------------------------
module nap_regs import nap_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.outer_gain  <= RST_OUTER_GAIN;
			cfg_q.inner_gain  <= RST_INNER_GAIN;
			cfg_q.outer_delay <= RST_OUTER_DELAY;
			cfg_q.inner_delay <= RST_INNER_DELAY;
		end else if (wr_en) begin
			case (idx)
				REG_OUTER_GAIN:  cfg_q.outer_gain  <= pwdata[GAIN_W-1:0];
				REG_INNER_GAIN:  cfg_q.inner_gain  <= pwdata[GAIN_W-1:0];
				REG_OUTER_DELAY: cfg_q.outer_delay <= pwdata[DELAY_W-1:0];
				REG_INNER_DELAY: cfg_q.inner_delay <= pwdata[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_OUTER_GAIN:  prdata = PDATA_W'(cfg_q.outer_gain);
			REG_INNER_GAIN:  prdata = PDATA_W'(cfg_q.inner_gain);
			REG_OUTER_DELAY: prdata = PDATA_W'(cfg_q.outer_delay);
			REG_INNER_DELAY: prdata = PDATA_W'(cfg_q.inner_delay);
			default:         prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/nap_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nap_ctrl: sequencer for one sample
// Steps the datapath through read, multiply, subtract and write-back, and
// owns both handshakes.
// ----------------------------------------------------------------------------
module nap_ctrl import nap_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_MUL_D;
			ST_MUL_D: state_nxt = ST_SUB_V;
			ST_SUB_V: state_nxt = ST_SUB_T;
			ST_SUB_T: state_nxt = ST_MUL_T;
			ST_MUL_T: state_nxt = ST_FIN;
			ST_FIN:   if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_MUL_D: cmd.mul_d = 1'b1;
			ST_SUB_V: cmd.sub_v = 1'b1;
			ST_SUB_T: cmd.sub_t = 1'b1;
			ST_MUL_T: cmd.mul_t = 1'b1;
			ST_FIN:   cmd.fin   = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/nap_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nap_dp: delay lines and fixed-point arithmetic
// Two delay memories with a shared write index, a fill count standing in for
// the cleared state, and the multiply/round/saturate steps.
// ----------------------------------------------------------------------------
module nap_dp import nap_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cmd_t                       cmd,
	input  wire cfg_t                       cfg,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	output logic signed      [SAMPLE_W-1:0] sample_out
);

	logic signed [SAMPLE_W-1:0] outer_mem [LINE_DEPTH];
	logic signed [SAMPLE_W-1:0] inner_mem [LINE_DEPTH];

	logic [ADDR_W-1:0] wr_q;
	logic [ADDR_W:0]   fill_q;
	logic [ADDR_W-1:0] ord_addr;
	logic [ADDR_W-1:0] ird_addr;
	logic              o_hit;
	logic              i_hit;

	logic                       o_vld_q;
	logic                       i_vld_q;
	logic signed [SAMPLE_W-1:0] o_rd_q;
	logic signed [SAMPLE_W-1:0] i_rd_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] d_q;
	logic signed [SAMPLE_W-1:0] dn_q;
	logic signed [PROD_W-1:0]   pd1_q;
	logic signed [PROD_W-1:0]   pd2_q;
	logic signed [PROD_W-1:0]   pv_q;
	logic signed [PROD_W-1:0]   pt_q;
	logic signed [SAMPLE_W-1:0] v_q;
	logic signed [SAMPLE_W-1:0] t_q;
	logic signed [SAMPLE_W-1:0] o_q;
	logic signed [SAMPLE_W-1:0] out_q;

	logic signed [SAMPLE_W-1:0] d_m;
	logic signed [SAMPLE_W-1:0] dn_m;
	logic signed [GAIN_W:0]     g1;
	logic signed [GAIN_W:0]     g2;
	logic signed [SAMPLE_W-1:0] y;

	// Delay modulo depth, then step back from the write index
	assign ord_addr = wr_q - ADDR_W'(32'(cfg.outer_delay));
	assign ird_addr = wr_q - ADDR_W'(32'(cfg.inner_delay));

	// Entries at or beyond the fill count have not been written since reset
	assign o_hit = fill_q[ADDR_W] || ({1'b0, ord_addr} < fill_q);
	assign i_hit = fill_q[ADDR_W] || ({1'b0, ird_addr} < fill_q);

	assign g1   = $signed({1'b0, cfg.outer_gain});
	assign g2   = $signed({1'b0, cfg.inner_gain});
	assign d_m  = o_vld_q ? o_rd_q : '0;
	assign dn_m = i_vld_q ? i_rd_q : '0;
	assign y    = sat24(SUM_W'(rnd16(pt_q)) + SUM_W'(dn_q));

	assign sample_out = out_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			o_rd_q <= outer_mem[ord_addr];
			i_rd_q <= inner_mem[ird_addr];
		end
		if (cmd.fin) begin
			outer_mem[wr_q] <= y;
			inner_mem[wr_q] <= t_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			fill_q <= '0;
		end else if (cmd.fin) begin
			wr_q <= wr_q + 1'b1;
			if (!fill_q[ADDR_W]) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q     <= sample_in;
			o_vld_q <= o_hit;
			i_vld_q <= i_hit;
		end
		if (cmd.mul_d) begin
			d_q   <= d_m;
			dn_q  <= dn_m;
			pd1_q <= d_m * g1;
			pd2_q <= dn_m * g2;
		end
		if (cmd.sub_v) begin
			v_q <= sat24(SUM_W'(x_q) - SUM_W'(rnd16(pd1_q)));
		end
		if (cmd.sub_t) begin
			t_q  <= sat24(SUM_W'(v_q) - SUM_W'(rnd16(pd2_q)));
			pv_q <= v_q * g1;
		end
		if (cmd.mul_t) begin
			pt_q <= t_q * g2;
			o_q  <= sat24(SUM_W'(rnd16(pv_q)) + SUM_W'(d_q));
		end
		if (cmd.fin) begin
			out_q <= o_q;
		end
	end

endmodule
`default_nettype wire

/* hdl/nested_allpass_reverb_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nested_allpass_reverb_core: nested allpass reverberator, one sample in/out
// Output: out_valid is registered; it rises as the sequencer leaves its final
//   step with the output register free; that step holds while a result stalls.
// Input: no new sample is taken before the six-step sequence is through; the
//   steps share the multiply/saturate logic and one read port per delay line.
// Reset: arst_n clears control, write index and fill count at once; no
//   clearing pass, so in_ready is high as soon as reset is released.
// ----------------------------------------------------------------------------
module nested_allpass_reverb_core import nap_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// Input sample channel
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	// Output sample channel
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed      [SAMPLE_W-1:0] sample_out,
	// Configuration port
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [PADDR_W-1:0]         paddr,
	input  wire logic [PDATA_W-1:0]         pwdata,
	output logic      [PDATA_W-1:0]         prdata,
	output logic                            pready
);

	// Commands from the sequencer; every datapath register moves only on one
	cmd_t cmd;
	// Live regs; user must write them only while no transaction is in flight
	cfg_t cfg;

	nap_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer: accept in idle, step through the arithmetic, then hold in the
	// final step until the output register can take the result. The delay
	// lines are written in that same step, so a new transaction always reads
	// what the previous one left.
	nap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Datapath: both delay lines, the shared write index, the fill count that
	// makes never-written entries read as zero, and the arithmetic registers.
	nap_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.sample_in  (sample_in),
		.sample_out (sample_out)
	);

endmodule
`default_nettype wire

/* hdl/nap_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nap_checker: port-level checks for the reverb core
// Watches handshakes and sequencing as seen on the top-level ports.
// ----------------------------------------------------------------------------
module nap_checker import nap_pkg::*; (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic signed [SAMPLE_W-1:0] sample_out,
	input wire logic                       pready
);

	// Zero-wait configuration port
	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

	// A transaction keeps the input closed for the full arithmetic sequence
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready
			##1 !in_ready ##1 !in_ready)
		else $error("input reopened before result was formed");

	// A result appears only as the sequencer leaves its final step
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(sample_out))
		else $error("stalled result changed");

endmodule

bind nested_allpass_reverb_core nap_checker u_nap_checker (.*);
`default_nettype wire

/* test/allpass_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allpass_checker: predicts and checks the nested allpass reverb core
// Follows configuration writes on the register port, runs its own copy of
// both delay lines for every accepted input sample, and compares each output
// sample and register read-back against the prediction.
// ----------------------------------------------------------------------------
module allpass_checker import nap_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic signed [SAMPLE_W-1:0] sample_out,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [PADDR_W-1:0]         paddr,
	input  logic [PDATA_W-1:0]         pwdata,
	input  logic [PDATA_W-1:0]         prdata,
	input  logic                       pready,
	input  logic                       run_done,
	output int                         mismatches
);

	logic signed [SAMPLE_W-1:0] outer_echo [LINE_DEPTH];
	logic signed [SAMPLE_W-1:0] inner_echo [LINE_DEPTH];
	logic [ADDR_W-1:0]          wr_ptr;
	cfg_t                       settings;
	logic signed [SAMPLE_W-1:0] expected_samples [$];
	logic                       end_seen;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// round(a * g / 65536), halves rounded up, i.e. floor of (p + 0.5 LSB)
	function automatic longint gain_scale(input logic signed [SAMPLE_W-1:0] a,
	                                      input logic [GAIN_W-1:0] g);
		longint p;
		p = longint'(a) * longint'(g) + 64'sd32768;
		return p >>> 16;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] clip24(input longint x);
		if (x > 64'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (x < -64'sd8388608) begin
			return 24'sh800000;
		end
		return x[SAMPLE_W-1:0];
	endfunction

	task automatic run_allpass(input logic signed [SAMPLE_W-1:0] x);
		logic [ADDR_W-1:0]          rd_outer;
		logic [ADDR_W-1:0]          rd_inner;
		logic signed [SAMPLE_W-1:0] d;
		logic signed [SAMPLE_W-1:0] dn;
		logic signed [SAMPLE_W-1:0] v;
		logic signed [SAMPLE_W-1:0] o;
		logic signed [SAMPLE_W-1:0] t;
		logic signed [SAMPLE_W-1:0] y;
		rd_outer = wr_ptr - ADDR_W'(settings.outer_delay);
		rd_inner = wr_ptr - ADDR_W'(settings.inner_delay);
		d  = outer_echo[rd_outer];
		dn = inner_echo[rd_inner];
		v  = clip24(longint'(x) - gain_scale(d, settings.outer_gain));
		o  = clip24(gain_scale(v, settings.outer_gain) + longint'(d));
		t  = clip24(longint'(v) - gain_scale(dn, settings.inner_gain));
		y  = clip24(gain_scale(t, settings.inner_gain) + longint'(dn));
		inner_echo[wr_ptr] = t;
		outer_echo[wr_ptr] = y;
		wr_ptr = wr_ptr + 1'b1;
		expected_samples.push_back(o);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINE_DEPTH; i++) begin
				outer_echo[i] = '0;
				inner_echo[i] = '0;
			end
			wr_ptr   = '0;
			settings = '{outer_gain: RST_OUTER_GAIN, inner_gain: RST_INNER_GAIN,
			             outer_delay: RST_OUTER_DELAY, inner_delay: RST_INNER_DELAY};
			expected_samples.delete();
			mismatches = 0;
			end_seen   = 1'b0;
		end else begin : watch
			logic [PDATA_W-1:0]         read_want;
			logic signed [SAMPLE_W-1:0] want;
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					report_mismatch($sformatf("unexpected output sample %0d", sample_out));
				end else begin
					want = expected_samples.pop_front();
					if (sample_out !== want) begin
						report_mismatch($sformatf("sample_out %0d, predicted %0d",
						                          sample_out, want));
					end
				end
			end
			if (in_valid && in_ready) begin
				run_allpass(sample_in);
			end
			if (psel && penable && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_OUTER_GAIN:  read_want = PDATA_W'(settings.outer_gain);
					REG_INNER_GAIN:  read_want = PDATA_W'(settings.inner_gain);
					REG_OUTER_DELAY: read_want = PDATA_W'(settings.outer_delay);
					default:         read_want = PDATA_W'(settings.inner_delay);
				endcase
				if (pwrite) begin
					case (paddr[PADDR_W-1:2])
						REG_OUTER_GAIN:  settings.outer_gain  = pwdata[GAIN_W-1:0];
						REG_INNER_GAIN:  settings.inner_gain  = pwdata[GAIN_W-1:0];
						REG_OUTER_DELAY: settings.outer_delay = pwdata[DELAY_W-1:0];
						default:         settings.inner_delay = pwdata[DELAY_W-1:0];
					endcase
				end else if (prdata !== read_want) begin
					report_mismatch($sformatf("register at 0x%0h reads 0x%0h, predicted 0x%0h",
					                          paddr, prdata, read_want));
				end
			end
			if (run_done && !end_seen) begin
				end_seen = 1'b1;
				if (expected_samples.size() != 0) begin
					report_mismatch($sformatf("%0d predicted samples never came out",
					                          expected_samples.size()));
				end
			end
		end
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the nested allpass reverb core
// Drives directed and random audio samples through a series of gain and
// delay settings with bursty input and a stalling receiver; the checker
// beside the core predicts every output sample and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
	import nap_pkg::*;

	localparam int TIMEOUT_NS = 1_000_000;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

	// Receiver behaviour: ready throughout, coin toss, mostly stalled, fixed rhythm
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       out_ready = 1'b0;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [PADDR_W-1:0]         paddr;
	logic [PDATA_W-1:0]         pwdata;
	logic                       run_done;
	wire                        in_ready;
	wire                        out_valid;
	wire  signed [SAMPLE_W-1:0] sample_out;
	wire  [PDATA_W-1:0]         prdata;
	wire                        pready;
	int                         mismatches;

	rx_mode_t rx_mode;
	int       rx_tick = 0;
	int       sent_cnt = 0;
	int       recv_cnt = 0;
	int       burst_left;
	int       gap_max;

	nested_allpass_reverb_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	allpass_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.run_done   (run_done),
		.mismatches (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the core hangs on either channel
	initial begin
		#TIMEOUT_NS;
		$display("simulation failed");
		$finish;
	end

	// Count transactions on both channels so the sender knows when the core is drained
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			sent_cnt <= sent_cnt + 1;
		end
		if (out_valid && out_ready) begin
			recv_cnt <= recv_cnt + 1;
		end
	end

	// Receiver stall pattern, independent of the sender; updated on the falling edge
	always @(negedge clk) begin
		rx_tick <= rx_tick + 1;
		case (rx_mode)
			RX_ALWAYS:   out_ready <= 1'b1;
			RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE:   out_ready <= ($urandom_range(0, 5) == 0);
			RX_PERIODIC: out_ready <= ((rx_tick % 7) < 3);
			default:     out_ready <= 1'b1;
		endcase
	end

	// Random picks lean on the corners: extremes, tiny values, zero and full-scale delays
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		logic [31:0] r;
		int          near_zero;
		r         = $urandom();
		near_zero = int'($urandom_range(0, 511)) - 256;
		case ($urandom_range(0, 9))
			0:       return SAMPLE_MAX;
			1:       return SAMPLE_MIN;
			2, 3:    return near_zero[SAMPLE_W-1:0];
			default: return r[SAMPLE_W-1:0];
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return 16'd32768;
			default: return GAIN_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Short delays keep the feedback paths busy within a few dozen samples
	function automatic logic [DELAY_W-1:0] pick_delay();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2, 3:    return DELAY_W'($urandom_range(1, 400));
			default: return DELAY_W'($urandom_range(1, 24));
		endcase
	endfunction

	// Every task below starts and ends just after a falling edge
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		// Between bursts, drop valid for a random gap, then start a new burst
		if (burst_left == 0) begin
			if (gap_max > 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		// Hold valid and payload until the transaction completes
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	// Hold off the sender until every predicted sample has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (recv_cnt != sent_cnt) @(negedge clk);
	endtask

	task automatic apb_access(input logic [1:0] idx, input logic wr,
	                          input logic [GAIN_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= PDATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Only reconfigure an idle core; read each register back after writing it
	task automatic apply_settings(input logic [GAIN_W-1:0] g_outer,
	                              input logic [GAIN_W-1:0] g_inner,
	                              input logic [DELAY_W-1:0] d_outer,
	                              input logic [DELAY_W-1:0] d_inner);
		wait_drained();
		apb_access(REG_OUTER_GAIN, 1'b1, g_outer);
		apb_access(REG_OUTER_GAIN, 1'b0, '0);
		apb_access(REG_INNER_GAIN, 1'b1, g_inner);
		apb_access(REG_INNER_GAIN, 1'b0, '0);
		apb_access(REG_OUTER_DELAY, 1'b1, d_outer);
		apb_access(REG_OUTER_DELAY, 1'b0, '0);
		apb_access(REG_INNER_DELAY, 1'b1, d_inner);
		apb_access(REG_INNER_DELAY, 1'b0, '0);
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		sample_in  = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		run_done   = 1'b0;
		rx_mode    = RX_COIN;
		burst_left = 0;
		gap_max    = 4;

		// Single reset at the start; release on a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values read back, then full-scale samples against empty lines
		apb_access(REG_OUTER_GAIN, 1'b0, '0);
		apb_access(REG_INNER_GAIN, 1'b0, '0);
		apb_access(REG_OUTER_DELAY, 1'b0, '0);
		apb_access(REG_INNER_DELAY, 1'b0, '0);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample('0);

		// Maximum gains, one- and two-sample delays: drive every sum into saturation
		apply_settings('1, '1, 16'd1, 16'd2);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MIN);
		send_sample(24'sd1);
		send_sample(-24'sd1);

		// Zero gains and zero delays: reads land on the entry about to be written
		apply_settings('0, '0, '0, '0);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(24'sd12345);

		// Longest outer delay reaches past everything written so far
		apply_settings('1, '0, '1, 16'd1);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);

		// Half gains on odd values: products land exactly on a rounding half
		apply_settings(16'd32768, 16'd32768, 16'd1, 16'd1);
		send_sample(24'sd1);
		send_sample(-24'sd1);
		send_sample(24'sd3);
		send_sample(-24'sd3);

		// Random phases, each with fresh settings, its own receiver mode and gap length
		for (int p = 0; p < 9; p++) begin
			apply_settings(pick_gain(), pick_gain(), pick_delay(), pick_delay());
			rx_mode <= rx_mode_t'(p % 4);
			gap_max = (p % 3 == 0) ? 0 : $urandom_range(2, 12);
			for (int k = 0; k < 56; k++) begin
				// Once mid-phase, let the core run completely dry before carrying on
				if (p == 4 && k == 28) begin
					wait_drained();
				end
				send_sample(pick_sample());
			end
		end

		// Drain, keep the receiver ready for anything stray, then ask for the leftover check
		wait_drained();
		rx_mode <= RX_ALWAYS;
		repeat (20) @(negedge clk);
		run_done <= 1'b1;
		@(posedge clk);
		@(negedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
